### hw/rtl/pmct_pkg.sv
// Shared types, codes and constants for the PS/2 mouse packet cursor tracker.
package pmct_pkg;

  // Coordinate and field widths fixed by the interface.
  localparam int COORD_BITS        = 12;
  localparam int SIZE_BITS         = COORD_BITS + 1;
  localparam int WINDOW_BITS       = 16;
  localparam int CFG_DATA_BITS     = 16;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int OP_BITS           = 3;
  localparam int BYTE_BITS         = 8;
  localparam int NOW_BITS          = 32;
  localparam int TIME_BITS_DEFAULT = 32;

  // Operation codes carried in the op field of an input word.
  localparam logic [OP_BITS-1:0] OP_DATA         = 3'd0;
  localparam logic [OP_BITS-1:0] OP_TAKE_CLICK   = 3'd1;
  localparam logic [OP_BITS-1:0] OP_TAKE_DOUBLE  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_TAKE_RIGHT   = 3'd3;
  localparam logic [OP_BITS-1:0] OP_INJECT_CLICK = 3'd4;
  localparam logic [OP_BITS-1:0] OP_DRAIN        = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DOUBLE_WINDOW = 2'd2;

  // Configuration reset values.
  localparam logic [SIZE_BITS-1:0]   SCREEN_WIDTH_RST  = 13'd960;
  localparam logic [SIZE_BITS-1:0]   SCREEN_HEIGHT_RST = 13'd720;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RST        = 16'd350;

  // Cursor reset position.
  localparam logic [COORD_BITS-1:0] POS_X_RST = 12'd480;
  localparam logic [COORD_BITS-1:0] POS_Y_RST = 12'd360;

  // Packet byte positions.
  localparam logic [1:0] IDX_HEADER = 2'd0;
  localparam logic [1:0] IDX_XDELTA = 2'd1;
  localparam logic [1:0] IDX_YDELTA = 2'd2;

  // Header byte bit positions.
  localparam int HDR_LEFT_BIT  = 0;
  localparam int HDR_RIGHT_BIT = 1;
  localparam int HDR_SYNC_BIT  = 3;
  localparam int HDR_XSIGN_BIT = 4;
  localparam int HDR_YSIGN_BIT = 5;
  localparam logic [BYTE_BITS-1:0] HDR_OVF_MASK = 8'hC0;

  // Pointer acceleration: gain of 2 plus min(14, (|d|-4)^2/8) above |d| = 4.
  localparam logic [4:0] GAIN_BASE     = 5'd2;
  localparam logic [4:0] BOOST_MAX     = 5'd14;
  localparam logic [8:0] BOOST_BIAS    = 9'd4;
  localparam logic [8:0] BOOST_SAT_MAG = 9'd15;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN_X,
    ST_MOVE_X,
    ST_GAIN_Y,
    ST_MOVE_Y,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_item;
    logic gain_run;
    logic move_run;
    logic axis_y;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_moves;
    logic result_free;
  } status_t;

endpackage

### hw/rtl/pmct_ifs.sv
// Valid/ready channel interfaces for input words and result words.
interface pmct_in_if;
  logic                             valid;
  logic                             ready;
  logic [pmct_pkg::OP_BITS-1:0]     op;
  logic [pmct_pkg::BYTE_BITS-1:0]   data_byte;
  logic [pmct_pkg::NOW_BITS-1:0]    now_ms;

  modport source (output valid, output op, output data_byte, output now_ms, input ready);
  modport sink   (input valid, input op, input data_byte, input now_ms, output ready);
endinterface

interface pmct_out_if;
  logic                              valid;
  logic                              ready;
  logic [pmct_pkg::COORD_BITS-1:0]   cursor_x;
  logic [pmct_pkg::COORD_BITS-1:0]   cursor_y;
  logic                              left_down;
  logic                              right_down;
  logic                              click_pending;
  logic                              double_pending;
  logic                              right_pending;
  logic                              taken_flag;
  logic                              packet_done;
  logic                              byte_dropped;

  modport source (
    output valid, output cursor_x, output cursor_y, output left_down, output right_down,
    output click_pending, output double_pending, output right_pending,
    output taken_flag, output packet_done, output byte_dropped,
    input ready
  );
  modport sink (
    input valid, input cursor_x, input cursor_y, input left_down, input right_down,
    input click_pending, input double_pending, input right_pending,
    input taken_flag, input packet_done, input byte_dropped,
    output ready
  );
endinterface

### hw/rtl/pmct_ctrl.sv
// Controller state machine that sequences one input word through the datapath.
module pmct_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  pmct_pkg::status_t  status,
  output pmct_pkg::cmd_t     cmd
);

  pmct_pkg::state_t state;
  pmct_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pmct_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = status.item_moves ? pmct_pkg::ST_GAIN_X : pmct_pkg::ST_EMIT;
        end
      end
      pmct_pkg::ST_GAIN_X: state_next = pmct_pkg::ST_MOVE_X;
      pmct_pkg::ST_MOVE_X: state_next = pmct_pkg::ST_GAIN_Y;
      pmct_pkg::ST_GAIN_Y: state_next = pmct_pkg::ST_MOVE_Y;
      pmct_pkg::ST_MOVE_Y: state_next = pmct_pkg::ST_EMIT;
      pmct_pkg::ST_EMIT: begin
        if (status.result_free) begin
          state_next = pmct_pkg::ST_IDLE;
        end
      end
      default: state_next = pmct_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready    = 1'b0;
    cmd.take_item = 1'b0;
    cmd.gain_run  = 1'b0;
    cmd.move_run  = 1'b0;
    cmd.axis_y    = 1'b0;
    cmd.emit      = 1'b0;
    unique case (state)
      pmct_pkg::ST_IDLE: begin
        item_ready    = 1'b1;
        cmd.take_item = item_valid;
      end
      pmct_pkg::ST_GAIN_X: cmd.gain_run = 1'b1;
      pmct_pkg::ST_MOVE_X: cmd.move_run = 1'b1;
      pmct_pkg::ST_GAIN_Y: begin
        cmd.gain_run = 1'b1;
        cmd.axis_y   = 1'b1;
      end
      pmct_pkg::ST_MOVE_Y: begin
        cmd.move_run = 1'b1;
        cmd.axis_y   = 1'b1;
      end
      pmct_pkg::ST_EMIT: cmd.emit = status.result_free;
      default: ;
    endcase
  end

endmodule

### hw/rtl/pmct_datapath.sv
// Datapath: packet assembly, button and click flags, shared gain unit, cursor clamp,
// configuration registers and the result register.
module pmct_datapath #(
  parameter int TIME_BITS = pmct_pkg::TIME_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pmct_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [pmct_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic [pmct_pkg::OP_BITS-1:0]         op,
  input  logic [pmct_pkg::BYTE_BITS-1:0]       data_byte,
  input  logic [pmct_pkg::NOW_BITS-1:0]        now_ms,
  input  pmct_pkg::cmd_t                       cmd,
  output pmct_pkg::status_t                    status,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic [pmct_pkg::COORD_BITS-1:0]      cursor_x,
  output logic [pmct_pkg::COORD_BITS-1:0]      cursor_y,
  output logic                                 left_down,
  output logic                                 right_down,
  output logic                                 click_pending,
  output logic                                 double_pending,
  output logic                                 right_pending,
  output logic                                 taken_flag,
  output logic                                 packet_done,
  output logic                                 byte_dropped
);

  localparam int CB = pmct_pkg::COORD_BITS;
  localparam int SB = pmct_pkg::SIZE_BITS;
  localparam int SUM_BITS = CB + 4;
  localparam logic [SB-1:0] COORD_LIMIT = SB'(1) << CB;

  // Gain for a delta magnitude, 2..16.
  function automatic logic [4:0] gain_of(input logic [8:0] mag);
    logic [3:0] m;
    logic [6:0] sq;
    logic [4:0] g;
    m  = 4'(mag - pmct_pkg::BOOST_BIAS);
    sq = 7'(m * m);
    if (mag <= pmct_pkg::BOOST_BIAS) begin
      g = pmct_pkg::GAIN_BASE;
    end else if (mag >= pmct_pkg::BOOST_SAT_MAG) begin
      g = pmct_pkg::GAIN_BASE + pmct_pkg::BOOST_MAX;
    end else begin
      g = pmct_pkg::GAIN_BASE + 5'(sq >> 3);
    end
    return g;
  endfunction

  // Configuration.
  logic [SB-1:0]                       screen_width;
  logic [SB-1:0]                       screen_height;
  logic [pmct_pkg::WINDOW_BITS-1:0]    double_click_window;

  // Tracker state.
  logic [1:0]                          byte_index;
  logic [pmct_pkg::BYTE_BITS-1:0]      header_byte;
  logic [pmct_pkg::BYTE_BITS-1:0]      x_delta_byte;
  logic [pmct_pkg::BYTE_BITS-1:0]      y_delta_byte;
  logic [CB-1:0]                       pos_x;
  logic [CB-1:0]                       pos_y;
  logic                                left_held;
  logic                                right_held;
  logic                                left_edge_flag;
  logic                                right_edge_flag;
  logic                                double_flag;
  logic [TIME_BITS-1:0]                last_press_time;

  // Per-word result flags and the shared gain unit output.
  logic                                taken;
  logic                                done;
  logic                                dropped;
  logic signed [14:0]                  scaled;

  // Combinational helpers.
  logic [TIME_BITS-1:0]                now_t;
  logic [TIME_BITS-1:0]                gap;
  logic                                gap_short;
  logic                                left_now;
  logic                                right_now;
  logic signed [8:0]                   delta;
  logic [8:0]                          mag;
  logic [4:0]                          gain;
  logic [SB-1:0]                       size_raw;
  logic [SB-1:0]                       lim;
  logic [CB-1:0]                       pos_cur;
  logic signed [SUM_BITS-1:0]          sum;
  logic [CB-1:0]                       pos_new;

  assign now_t     = now_ms[TIME_BITS-1:0];
  assign gap       = now_t - last_press_time;
  assign gap_short = gap < TIME_BITS'(double_click_window);
  assign left_now  = header_byte[pmct_pkg::HDR_LEFT_BIT];
  assign right_now = header_byte[pmct_pkg::HDR_RIGHT_BIT];

  // A data byte in the last packet position with a clean header moves the cursor.
  assign status.item_moves  = (op == pmct_pkg::OP_DATA) &&
                              (byte_index != pmct_pkg::IDX_HEADER) &&
                              (byte_index != pmct_pkg::IDX_XDELTA) &&
                              ((header_byte & pmct_pkg::HDR_OVF_MASK) == '0);
  assign status.result_free = !result_valid || result_ready;

  // Gain unit: sign-extend the 9-bit delta, look up the gain, multiply.
  assign delta = cmd.axis_y ? $signed({header_byte[pmct_pkg::HDR_YSIGN_BIT], y_delta_byte})
                            : $signed({header_byte[pmct_pkg::HDR_XSIGN_BIT], x_delta_byte});
  assign mag   = delta[8] ? 9'(-delta) : 9'(delta);
  assign gain  = gain_of(mag);

  // Clamp unit: add the scaled delta and hold the result inside the screen.
  assign size_raw = cmd.axis_y ? screen_height : screen_width;
  assign pos_cur  = cmd.axis_y ? pos_y : pos_x;
  assign sum      = $signed({4'b0, pos_cur}) + SUM_BITS'(scaled);

  always_comb begin
    priority if (size_raw == '0) begin
      lim = SB'(1);
    end else if (size_raw > COORD_LIMIT) begin
      lim = COORD_LIMIT;
    end else begin
      lim = size_raw;
    end
  end

  always_comb begin
    priority if (sum < 0) begin
      pos_new = '0;
    end else if (sum >= $signed({{(SUM_BITS-SB){1'b0}}, lim})) begin
      pos_new = CB'(lim - SB'(1));
    end else begin
      pos_new = sum[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width        <= pmct_pkg::SCREEN_WIDTH_RST;
      screen_height       <= pmct_pkg::SCREEN_HEIGHT_RST;
      double_click_window <= pmct_pkg::WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pmct_pkg::CFG_SCREEN_WIDTH:  screen_width        <= cfg_data[SB-1:0];
        pmct_pkg::CFG_SCREEN_HEIGHT: screen_height       <= cfg_data[SB-1:0];
        pmct_pkg::CFG_DOUBLE_WINDOW: double_click_window <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index      <= pmct_pkg::IDX_HEADER;
      header_byte     <= '0;
      x_delta_byte    <= '0;
      pos_x           <= pmct_pkg::POS_X_RST;
      pos_y           <= pmct_pkg::POS_Y_RST;
      left_held       <= 1'b0;
      right_held      <= 1'b0;
      left_edge_flag  <= 1'b0;
      right_edge_flag <= 1'b0;
      double_flag     <= 1'b0;
      last_press_time <= '0;
      taken           <= 1'b0;
      done            <= 1'b0;
      dropped         <= 1'b0;
    end else if (cmd.take_item) begin
      taken   <= 1'b0;
      done    <= 1'b0;
      dropped <= 1'b0;
      unique case (op)
        pmct_pkg::OP_DATA: begin
          priority if (byte_index == pmct_pkg::IDX_HEADER) begin
            if (!data_byte[pmct_pkg::HDR_SYNC_BIT]) begin
              dropped <= 1'b1;
            end else begin
              header_byte <= data_byte;
              byte_index  <= pmct_pkg::IDX_XDELTA;
            end
          end else if (byte_index == pmct_pkg::IDX_XDELTA) begin
            x_delta_byte <= data_byte;
            byte_index   <= pmct_pkg::IDX_YDELTA;
          end else begin
            byte_index <= pmct_pkg::IDX_HEADER;
            if ((header_byte & pmct_pkg::HDR_OVF_MASK) != '0) begin
              dropped <= 1'b1;
            end else begin
              done <= 1'b1;
              if (left_now && !left_held) begin
                left_edge_flag  <= 1'b1;
                last_press_time <= now_t;
                if (gap_short) begin
                  double_flag <= 1'b1;
                end
              end
              if (right_now && !right_held) begin
                right_edge_flag <= 1'b1;
              end
              left_held  <= left_now;
              right_held <= right_now;
            end
          end
        end
        pmct_pkg::OP_TAKE_CLICK: begin
          taken          <= left_edge_flag;
          left_edge_flag <= 1'b0;
        end
        pmct_pkg::OP_TAKE_DOUBLE: begin
          taken       <= double_flag;
          double_flag <= 1'b0;
        end
        pmct_pkg::OP_TAKE_RIGHT: begin
          taken           <= right_edge_flag;
          right_edge_flag <= 1'b0;
        end
        pmct_pkg::OP_INJECT_CLICK: left_edge_flag <= 1'b1;
        pmct_pkg::OP_DRAIN: begin
          left_edge_flag  <= 1'b0;
          double_flag     <= 1'b0;
          right_edge_flag <= 1'b0;
        end
        default: ;
      endcase
    end else if (cmd.move_run) begin
      if (cmd.axis_y) begin
        pos_y <= pos_new;
      end else begin
        pos_x <= pos_new;
      end
    end
  end

  // The y byte and the scaled delta are payload only.
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      y_delta_byte <= data_byte;
    end
    if (cmd.gain_run) begin
      scaled <= 15'(delta * $signed({1'b0, gain}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cursor_x       <= pos_x;
      cursor_y       <= pos_y;
      left_down      <= left_held;
      right_down     <= right_held;
      click_pending  <= left_edge_flag;
      double_pending <= double_flag;
      right_pending  <= right_edge_flag;
      taken_flag     <= taken;
      packet_done    <= done;
      byte_dropped   <= dropped;
    end
  end

endmodule

### hw/rtl/ps2_mouse_packet_cursor_tracker.sv
// Top level of the PS/2 mouse packet cursor tracker: controller, datapath and channels.
//
// The tracker takes one word per operation from the item channel: a mouse data byte
// or a flag operation (take click, take double click, take right click, inject a
// click, drain all flags), together with the current millisecond time. Data bytes
// are gathered into three-byte packets; a header byte without its sync bit is
// dropped so the stream can resync, and a packet whose header shows an overflow is
// dropped when its last byte arrives. A completed packet updates the button state,
// latches left and right press edges, flags a double click when the left press
// follows the previous one by less than the double-click window, and moves the
// cursor by each delta times an acceleration gain of 2 to 16, clamped to the
// configured screen. Every word yields exactly one result word on the result
// channel carrying the cursor, buttons, pending flags and per-word status. A word
// that completes a moving packet first passes through a gain step and a move
// step for x and then for y, since a single shared gain multiplier and a single
// add-and-clamp unit handle both axes; any other word goes straight to the emit
// state. The item channel is ready only while the controller is idle, so one word
// is in progress at a time; a finished result waits in the output register while
// the next word is accepted and processed, and only the final load into that
// register waits on the result channel. The user must write the configuration
// registers through cfg_we, cfg_index and cfg_data only while the block is idle;
// the block does not enforce this. There is no clearing pass after reset.
module ps2_mouse_packet_cursor_tracker #(
  parameter int TIME_BITS = pmct_pkg::TIME_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pmct_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pmct_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  pmct_in_if.sink                             item,
  pmct_out_if.source                          result
);

  // Command and status between the sequencer and the datapath.
  pmct_pkg::cmd_t    cmd;
  pmct_pkg::status_t status;

  // The controller owns the item handshake and steps the datapath through the
  // gain and move steps of each axis when a packet completes.
  pmct_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // The datapath holds all tracker state, the configuration and the result register.
  pmct_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .op             (item.op),
    .data_byte      (item.data_byte),
    .now_ms         (item.now_ms),
    .cmd            (cmd),
    .status         (status),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .cursor_x       (result.cursor_x),
    .cursor_y       (result.cursor_y),
    .left_down      (result.left_down),
    .right_down     (result.right_down),
    .click_pending  (result.click_pending),
    .double_pending (result.double_pending),
    .right_pending  (result.right_pending),
    .taken_flag     (result.taken_flag),
    .packet_done    (result.packet_done),
    .byte_dropped   (result.byte_dropped)
  );

endmodule

### hw/rtl/pmct_checker.sv
// Port-level assertions for the PS/2 mouse packet cursor tracker, bound to the top level.
module pmct_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            item_valid,
  input logic                            item_ready,
  input logic                            result_valid,
  input logic                            result_ready,
  input logic [pmct_pkg::COORD_BITS-1:0] cursor_x,
  input logic [pmct_pkg::COORD_BITS-1:0] cursor_y,
  input logic                            taken_flag,
  input logic                            packet_done,
  input logic                            byte_dropped
);

  // A stalled result word keeps its cursor fields.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(cursor_x) && $stable(cursor_y))
    else $error("result word changed while stalled");

  // One word is in progress at a time, so acceptance closes the item channel.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item channel stayed ready after an accepted word");

  // A byte never both completes a packet and is dropped.
  a_done_or_drop: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(packet_done && byte_dropped))
    else $error("packet reported both done and dropped");

  // A taken flag comes only from a flag operation, never from a data byte.
  a_taken_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(taken_flag && (packet_done || byte_dropped)))
    else $error("taken flag reported on a data byte");

endmodule

bind ps2_mouse_packet_cursor_tracker pmct_checker u_pmct_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .cursor_x     (result.cursor_x),
  .cursor_y     (result.cursor_y),
  .taken_flag   (result.taken_flag),
  .packet_done  (result.packet_done),
  .byte_dropped (result.byte_dropped)
);

### verif/testbench.sv
// Self-checking testbench for the PS/2 mouse packet cursor tracker.
//
// Input words are built by a stimulus process and placed on a backlog. A
// clocked driver offers them on the item channel in bursts with random gaps.
// When a word is accepted, the driver runs it through a behavioral copy of
// the tracker and stores the expected result word. A clocked monitor takes
// result words under its own stall pattern and compares each one, field by
// field, with the oldest stored expectation. Screen size and double-click
// window are changed only between phases, after every result has come back.
module testbench;

  // Op codes that the block has no use for; they must leave the state alone.
  localparam logic [pmct_pkg::OP_BITS-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [pmct_pkg::OP_BITS-1:0] OP_SPARE_7 = 3'd7;

  // Pointer acceleration and sign handling of the 9-bit deltas.
  localparam int BASE_GAIN   = 2;
  localparam int BOOST_KNEE  = 4;
  localparam int BOOST_DIV   = 8;
  localparam int BOOST_CAP   = 14;
  localparam int SIGN_WEIGHT = 1 << pmct_pkg::BYTE_BITS;
  localparam int COORD_SPAN  = 1 << pmct_pkg::COORD_BITS;

  // Run control.
  localparam int MAX_REPORTED       = 10;
  localparam int IDLE_LIMIT         = 3000;
  localparam int SETTLE_CYCLES      = 12;
  localparam int HOLD_CYCLES        = 400;
  localparam int HOLD_AFTER         = 100;
  localparam int RANDOM_PER_SETTING = 106;

  typedef struct packed {
    logic [pmct_pkg::OP_BITS-1:0]   op;
    logic [pmct_pkg::BYTE_BITS-1:0] data_byte;
    logic [pmct_pkg::NOW_BITS-1:0]  now_ms;
  } mouse_word_t;

  typedef struct packed {
    logic [pmct_pkg::COORD_BITS-1:0] cursor_x;
    logic [pmct_pkg::COORD_BITS-1:0] cursor_y;
    logic                            left_down;
    logic                            right_down;
    logic                            click_pending;
    logic                            double_pending;
    logic                            right_pending;
    logic                            taken_flag;
    logic                            packet_done;
    logic                            byte_dropped;
  } tracker_report_t;

  // Receiver behaviors, picked at random by the monitor.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_PATTERN,
    RX_COIN,
    RX_SPARSE
  } rx_mode_t;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                cfg_we;
  logic [pmct_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [pmct_pkg::CFG_DATA_BITS-1:0]  cfg_data;

  pmct_in_if  item_ch();
  pmct_out_if result_ch();

  ps2_mouse_packet_cursor_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Behavioral copy of the tracker: configuration, packet assembly state,
  // cursor, buttons and the latched flags.
  logic [pmct_pkg::SIZE_BITS-1:0]   scr_w        = pmct_pkg::SCREEN_WIDTH_RST;
  logic [pmct_pkg::SIZE_BITS-1:0]   scr_h        = pmct_pkg::SCREEN_HEIGHT_RST;
  logic [pmct_pkg::WINDOW_BITS-1:0] dbl_window   = pmct_pkg::WINDOW_RST;
  logic [1:0]                       pkt_pos      = pmct_pkg::IDX_HEADER;
  logic [pmct_pkg::BYTE_BITS-1:0]   pkt_header   = '0;
  logic [pmct_pkg::BYTE_BITS-1:0]   pkt_xbyte    = '0;
  logic [pmct_pkg::COORD_BITS-1:0]  cur_x        = pmct_pkg::POS_X_RST;
  logic [pmct_pkg::COORD_BITS-1:0]  cur_y        = pmct_pkg::POS_Y_RST;
  logic                             left_btn     = 1'b0;
  logic                             right_btn    = 1'b0;
  logic                             click_flag   = 1'b0;
  logic                             rclick_flag  = 1'b0;
  logic                             dbl_flag     = 1'b0;
  logic [pmct_pkg::NOW_BITS-1:0]    last_left_ms = '0;

  // Words still to be offered, and result words still to come back.
  mouse_word_t     outgoing_words[$];
  tracker_report_t awaited_reports[$];

  logic [pmct_pkg::OP_BITS-1:0] flag_ops[5] = '{pmct_pkg::OP_TAKE_CLICK,
                                                pmct_pkg::OP_TAKE_DOUBLE,
                                                pmct_pkg::OP_TAKE_RIGHT,
                                                pmct_pkg::OP_INJECT_CLICK,
                                                pmct_pkg::OP_DRAIN};

  // A delta of d pixels moves the cursor by d times the gain, which rises
  // quadratically above a magnitude of four and saturates.
  function automatic int scaled_delta(input int d);
    int mag;
    int boost;
    mag = (d < 0) ? -d : d;
    boost = 0;
    if (mag > BOOST_KNEE) boost = ((mag - BOOST_KNEE) * (mag - BOOST_KNEE)) / BOOST_DIV;
    if (boost > BOOST_CAP) boost = BOOST_CAP;
    return d * (BASE_GAIN + boost);
  endfunction

  // A zero screen size acts as one pixel, and a size past the coordinate
  // range is cut to that range.
  function automatic logic [pmct_pkg::COORD_BITS-1:0] clamp_coord(
      input logic [pmct_pkg::COORD_BITS-1:0] pos,
      input int delta,
      input logic [pmct_pkg::SIZE_BITS-1:0] size);
    int lim;
    int p;
    lim = int'(size);
    if (lim < 1) lim = 1;
    if (lim > COORD_SPAN) lim = COORD_SPAN;
    p = int'(pos) + delta;
    if (p < 0) p = 0;
    if (p >= lim) p = lim - 1;
    return p[pmct_pkg::COORD_BITS-1:0];
  endfunction

  // Advances the behavioral copy by one word and returns the result word
  // that the block must produce for it.
  function automatic tracker_report_t track_word(input mouse_word_t w);
    tracker_report_t r;
    int dx;
    int dy;
    logic left_now;
    logic right_now;
    logic [pmct_pkg::NOW_BITS-1:0] since_press;
    r = '0;
    case (w.op)
      pmct_pkg::OP_DATA: begin
        if (pkt_pos == pmct_pkg::IDX_HEADER) begin
          // A header must carry its sync bit, or the byte is thrown away.
          if (!w.data_byte[pmct_pkg::HDR_SYNC_BIT]) r.byte_dropped = 1'b1;
          else begin
            pkt_header = w.data_byte;
            pkt_pos = pmct_pkg::IDX_XDELTA;
          end
        end else if (pkt_pos == pmct_pkg::IDX_XDELTA) begin
          pkt_xbyte = w.data_byte;
          pkt_pos = pmct_pkg::IDX_YDELTA;
        end else begin
          pkt_pos = pmct_pkg::IDX_HEADER;
          if ((pkt_header & pmct_pkg::HDR_OVF_MASK) != '0) r.byte_dropped = 1'b1;
          else begin
            dx = int'(pkt_xbyte) -
                 (pkt_header[pmct_pkg::HDR_XSIGN_BIT] ? SIGN_WEIGHT : 0);
            dy = int'(w.data_byte) -
                 (pkt_header[pmct_pkg::HDR_YSIGN_BIT] ? SIGN_WEIGHT : 0);
            left_now = pkt_header[pmct_pkg::HDR_LEFT_BIT];
            right_now = pkt_header[pmct_pkg::HDR_RIGHT_BIT];
            if (left_now && !left_btn) begin
              click_flag = 1'b1;
              since_press = w.now_ms - last_left_ms;
              if (since_press < dbl_window) dbl_flag = 1'b1;
              last_left_ms = w.now_ms;
            end
            if (right_now && !right_btn) rclick_flag = 1'b1;
            left_btn = left_now;
            right_btn = right_now;
            cur_x = clamp_coord(cur_x, scaled_delta(dx), scr_w);
            cur_y = clamp_coord(cur_y, scaled_delta(dy), scr_h);
            r.packet_done = 1'b1;
          end
        end
      end
      pmct_pkg::OP_TAKE_CLICK: begin
        r.taken_flag = click_flag;
        click_flag = 1'b0;
      end
      pmct_pkg::OP_TAKE_DOUBLE: begin
        r.taken_flag = dbl_flag;
        dbl_flag = 1'b0;
      end
      pmct_pkg::OP_TAKE_RIGHT: begin
        r.taken_flag = rclick_flag;
        rclick_flag = 1'b0;
      end
      pmct_pkg::OP_INJECT_CLICK: click_flag = 1'b1;
      pmct_pkg::OP_DRAIN: begin
        click_flag = 1'b0;
        dbl_flag = 1'b0;
        rclick_flag = 1'b0;
      end
      default: ;
    endcase
    r.cursor_x = cur_x;
    r.cursor_y = cur_y;
    r.left_down = left_btn;
    r.right_down = right_btn;
    r.click_pending = click_flag;
    r.double_pending = dbl_flag;
    r.right_pending = rclick_flag;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. A word stays on the channel until it is taken. Between bursts of
  // random length the driver leaves the channel empty for a random number of
  // cycles; about a third of the bursts run straight into the next one.
  // ---------------------------------------------------------------------------
  mouse_word_t on_offer;
  int          burst_left;
  int          gap_left;

  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      item_ch.op <= pmct_pkg::OP_DATA;
      item_ch.data_byte <= '0;
      item_ch.now_ms <= '0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      // The expectation is formed at the edge that accepts the word, so the
      // copy advances in exactly the order the block sees the words.
      if (item_ch.valid && item_ch.ready) awaited_reports.push_back(track_word(on_offer));
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item_ch.valid <= 1'b0;
        end else if (outgoing_words.size() > 0) begin
          on_offer = outgoing_words.pop_front();
          item_ch.op <= on_offer.op;
          item_ch.data_byte <= on_offer.data_byte;
          item_ch.now_ms <= on_offer.now_ms;
          item_ch.valid <= 1'b1;
          if (burst_left > 1) burst_left--;
          else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
          end
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and checker. Ready follows one of four behaviors: always open, a
  // rotating bit pattern, a fair coin, or mostly closed. Once, after a hundred
  // result words, ready is held low for a long stretch so that the output
  // register fills and the block stops taking words while the driver keeps
  // offering them.
  // ---------------------------------------------------------------------------
  int              results_seen = 0;
  int              mismatches   = 0;
  int              hold_left;
  int              stall_phase;
  bit              hold_done = 1'b0;
  logic [15:0]     ready_pattern;
  rx_mode_t        stall_mode;
  tracker_report_t got_report;
  tracker_report_t want_report;

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTED)
        $display("result word %0d: %s expected %0d, got %0d",
                 results_seen, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_left = 0;
      stall_phase = 0;
      stall_mode = RX_OPEN;
      ready_pattern = 16'hB5E3;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got_report = {result_ch.cursor_x, result_ch.cursor_y, result_ch.left_down,
                      result_ch.right_down, result_ch.click_pending,
                      result_ch.double_pending, result_ch.right_pending,
                      result_ch.taken_flag, result_ch.packet_done, result_ch.byte_dropped};
        if (awaited_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED)
            $display("result word %0d arrived with nothing expected", results_seen);
        end else begin
          want_report = awaited_reports.pop_front();
          check_field("cursor_x", 16'(want_report.cursor_x), 16'(got_report.cursor_x));
          check_field("cursor_y", 16'(want_report.cursor_y), 16'(got_report.cursor_y));
          check_field("left_down", 16'(want_report.left_down), 16'(got_report.left_down));
          check_field("right_down", 16'(want_report.right_down),
                      16'(got_report.right_down));
          check_field("click_pending", 16'(want_report.click_pending),
                      16'(got_report.click_pending));
          check_field("double_pending", 16'(want_report.double_pending),
                      16'(got_report.double_pending));
          check_field("right_pending", 16'(want_report.right_pending),
                      16'(got_report.right_pending));
          check_field("taken_flag", 16'(want_report.taken_flag),
                      16'(got_report.taken_flag));
          check_field("packet_done", 16'(want_report.packet_done),
                      16'(got_report.packet_done));
          check_field("byte_dropped", 16'(want_report.byte_dropped),
                      16'(got_report.byte_dropped));
        end
        results_seen++;
      end

      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end

      stall_phase++;
      if (stall_phase % 64 == 0) stall_mode = rx_mode_t'($urandom_range(0, 3));
      ready_pattern = {ready_pattern[14:0], ready_pattern[15]};

      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          RX_OPEN:    result_ch.ready <= 1'b1;
          RX_PATTERN: result_ch.ready <= ready_pattern[0];
          RX_COIN:    result_ch.ready <= ($urandom_range(0, 1) == 1);
          default:    result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog: the run is stuck if no word moves on either channel for long.
  // The longest legal quiet stretch is the receiver's hold plus a few gaps.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d results still awaited",
                 IDLE_LIMIT, awaited_reports.size());
        $display("** ps2_mouse_packet_cursor_tracker: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  logic [pmct_pkg::NOW_BITS-1:0] ms_clock = '0;

  task automatic queue_word(input logic [pmct_pkg::OP_BITS-1:0] op,
                            input logic [pmct_pkg::BYTE_BITS-1:0] b,
                            input logic [pmct_pkg::NOW_BITS-1:0] now);
    mouse_word_t w;
    w.op = op;
    w.data_byte = b;
    w.now_ms = now;
    outgoing_words.push_back(w);
  endtask

  // The copy is updated once the register write has been clocked into the block.
  task automatic write_reg(input logic [pmct_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [pmct_pkg::CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pmct_pkg::CFG_SCREEN_WIDTH:  scr_w = val[pmct_pkg::SIZE_BITS-1:0];
      pmct_pkg::CFG_SCREEN_HEIGHT: scr_h = val[pmct_pkg::SIZE_BITS-1:0];
      pmct_pkg::CFG_DOUBLE_WINDOW: dbl_window = val[pmct_pkg::WINDOW_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int width, input int height, input int window);
    write_reg(pmct_pkg::CFG_SCREEN_WIDTH, pmct_pkg::CFG_DATA_BITS'(width));
    write_reg(pmct_pkg::CFG_SCREEN_HEIGHT, pmct_pkg::CFG_DATA_BITS'(height));
    write_reg(pmct_pkg::CFG_DOUBLE_WINDOW, pmct_pkg::CFG_DATA_BITS'(window));
  endtask

  // Every word yields a result, so once the backlog is empty and nothing is
  // awaited the block is idle; a short settle covers its longest latency.
  task automatic wait_drained();
    while (outgoing_words.size() != 0 || item_ch.valid || awaited_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly small deltas, where the gain curve bends, with its sign matching
  // the header; otherwise any byte, which may disagree with the sign bit.
  function automatic logic [pmct_pkg::BYTE_BITS-1:0] delta_byte(input logic negative);
    int mag;
    if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 255));
    mag = $urandom_range(0, 24);
    return negative ? 8'(SIGN_WEIGHT - mag) : 8'(mag);
  endfunction

  // Mostly whole packets with random content and a slowly advancing clock, so
  // that presses fall both inside and outside the double-click window. The
  // rest are flag operations, spare op codes and stray bytes that knock the
  // packet framing out of step.
  task automatic queue_random_words(input int count);
    int made;
    int roll;
    logic [pmct_pkg::BYTE_BITS-1:0] hdr;
    made = 0;
    while (made < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        ms_clock += $urandom_range(0, 160);
        if ($urandom_range(0, 24) == 0) ms_clock = $urandom();
        hdr = 8'($urandom_range(0, 255));
        hdr[pmct_pkg::HDR_SYNC_BIT] = 1'b1;
        if ($urandom_range(0, 9) != 0) hdr = hdr & ~pmct_pkg::HDR_OVF_MASK;
        queue_word(pmct_pkg::OP_DATA, hdr, $urandom());
        queue_word(pmct_pkg::OP_DATA, delta_byte(hdr[pmct_pkg::HDR_XSIGN_BIT]), $urandom());
        queue_word(pmct_pkg::OP_DATA, delta_byte(hdr[pmct_pkg::HDR_YSIGN_BIT]), ms_clock);
        made += 3;
      end else if (roll < 90) begin
        queue_word(flag_ops[$urandom_range(0, 4)], 8'($urandom_range(0, 255)), $urandom());
        made++;
      end else if (roll < 94) begin
        queue_word(($urandom_range(0, 1) == 1) ? OP_SPARE_7 : OP_SPARE_6,
                   8'($urandom_range(0, 255)), $urandom());
        made++;
      end else begin
        queue_word(pmct_pkg::OP_DATA, 8'($urandom_range(0, 255)), $urandom());
        made++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = pmct_pkg::CFG_SCREEN_WIDTH;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Shrink the screen before any packet: the cursor must still report its
    // reset position, which now lies outside the screen.
    apply_setting(200, 150, int'(pmct_pkg::WINDOW_RST));
    queue_word(pmct_pkg::OP_INJECT_CLICK, 8'h00, 32'd0);
    queue_word(pmct_pkg::OP_TAKE_RIGHT, 8'hFF, 32'hFFFF_FFFF);
    wait_drained();
    apply_setting(int'(pmct_pkg::SCREEN_WIDTH_RST), int'(pmct_pkg::SCREEN_HEIGHT_RST),
                  int'(pmct_pkg::WINDOW_RST));

    // Header without its sync bit is dropped.
    queue_word(pmct_pkg::OP_DATA, 8'h00, 32'd0);
    // First left press, compared with a last press time of zero: a double
    // click at once. The x delta is the largest positive one.
    queue_word(pmct_pkg::OP_DATA, 8'h09, 32'd0);
    queue_word(pmct_pkg::OP_DATA, 8'hFF, 32'd0);
    queue_word(pmct_pkg::OP_DATA, 8'h05, 32'd100);
    queue_word(pmct_pkg::OP_TAKE_CLICK, 8'h00, 32'd0);
    queue_word(pmct_pkg::OP_TAKE_DOUBLE, 8'h00, 32'd0);
    queue_word(pmct_pkg::OP_INJECT_CLICK, 8'h00, 32'd0);
    queue_word(pmct_pkg::OP_DRAIN, 8'h00, 32'd0);
    queue_word(OP_SPARE_6, 8'hA5, 32'h5A5A_5A5A);
    queue_word(OP_SPARE_7, 8'h5A, 32'hA5A5_A5A5);
    // Right press with left released; x delta -256 and y delta -4, late in
    // the time range.
    queue_word(pmct_pkg::OP_DATA, 8'h3A, 32'd0);
    queue_word(pmct_pkg::OP_DATA, 8'h00, 32'd0);
    queue_word(pmct_pkg::OP_DATA, 8'hFC, 32'hFFFF_FF00);
    queue_word(pmct_pkg::OP_TAKE_RIGHT, 8'h00, 32'd0);
    // A packet with both overflow bits set and one with only bit 6 set are dropped on their last byte.
    queue_word(pmct_pkg::OP_DATA, 8'hC9, 32'd0);
    queue_word(pmct_pkg::OP_DATA, 8'h12, 32'd0);
    queue_word(pmct_pkg::OP_DATA, 8'h34, 32'd0);
    queue_word(pmct_pkg::OP_DATA, 8'h59, 32'd0);
    queue_word(pmct_pkg::OP_DATA, 8'h80, 32'd0);
    queue_word(pmct_pkg::OP_DATA, 8'h7F, 32'd0);
    // Left press at a time below the previous press: the unsigned gap wraps
    // to a large value, so no double click is flagged.
    queue_word(pmct_pkg::OP_DATA, 8'h29, 32'd0);
    queue_word(pmct_pkg::OP_DATA, 8'h04, 32'd0);
    queue_word(pmct_pkg::OP_DATA, 8'h80, 32'h0000_0010);
    queue_word(pmct_pkg::OP_TAKE_DOUBLE, 8'h00, 32'd0);
    // The stimulus now waits until every result of the directed part is back.
    wait_drained();

    // Zero width, a height past the coordinate range, and no double clicks.
    apply_setting(0, 8191, 0);
    queue_random_words(RANDOM_PER_SETTING);
    wait_drained();
    // Widest screen, one row, and the longest window.
    apply_setting(COORD_SPAN, 1, 65535);
    queue_random_words(RANDOM_PER_SETTING);
    wait_drained();
    apply_setting(1, COORD_SPAN, 350);
    queue_random_words(RANDOM_PER_SETTING);
    wait_drained();
    apply_setting($urandom_range(1, COORD_SPAN), $urandom_range(1, COORD_SPAN),
                  $urandom_range(0, 65535));
    queue_random_words(RANDOM_PER_SETTING);
    wait_drained();
    apply_setting(640, 480, 200);
    queue_random_words(RANDOM_PER_SETTING);
    wait_drained();

    if (mismatches == 0 && awaited_reports.size() == 0)
      $display("** ps2_mouse_packet_cursor_tracker: PASSED **");
    else
      $display("** ps2_mouse_packet_cursor_tracker: FAILED **");
    $finish;
  end

endmodule
